@@ rtl/core/nrs_pkg.sv @@
`timescale 1ns / 1ps

package nrs_pkg;

    // Field widths of the transfer payloads and configuration registers.
    localparam int KIND_W     = 2;
    localparam int OPCODE_W   = 4;
    localparam int RCODE_W    = 4;
    localparam int ID_W       = 16;
    localparam int TCOUNT_W   = 5;
    localparam int INTERVAL_W = 16;
    localparam int MAXRET_W   = 4;
    localparam int ATTEMPT_W  = 5;
    localparam int TIDX_W     = 4;
    localparam int CFG_DATA_W = 16;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // DNS header codes that make a reply acceptable.
    localparam logic [OPCODE_W-1:0] OPC_NOTIFY    = 4'd4;
    localparam logic [RCODE_W-1:0]  RCODE_NOERROR = 4'd0;
    localparam logic [RCODE_W-1:0]  RCODE_NOTIMP  = 4'd4;

    // Reset values of the configuration registers.
    localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RST = 16'd15;
    localparam logic [MAXRET_W-1:0]   MAX_RETRIES_RST    = 4'd5;

    typedef enum logic [1:0] {
        CFG_TARGET_COUNT   = 2'd0,
        CFG_RETRY_INTERVAL = 2'd1,
        CFG_MAX_RETRIES    = 2'd2,
        CFG_SOA_KNOWN      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TCOUNT_W-1:0]   target_count;
        logic [INTERVAL_W-1:0] retry_interval;
        logic [MAXRET_W-1:0]   max_retries;
        logic                  soa_known;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OPCODE_W-1:0] reply_opcode;
        logic                reply_is_response;
        logic [ID_W-1:0]     reply_id;
        logic [RCODE_W-1:0]  reply_rcode;
        logic [ID_W-1:0]     fresh_id;
    } t_in_item;

    typedef struct packed {
        logic                 send_now;
        logic [TIDX_W-1:0]    target_index;
        logic [ID_W-1:0]      sent_id;
        logic [ATTEMPT_W-1:0] attempt_number;
        logic                 include_soa;
        logic                 busy_res;
        logic                 finished;
    } t_out_item;

endpackage

@@ rtl/core/notify_retry_sender.sv @@
`timescale 1ns / 1ps
// Path: a transfer accepted on the input is held in the input register, then
// written into the result register, which offers it on the output.
// Throughput: one item per cycle; a full result register that is stalled
// holds the input register, which then stalls the input channel.
// Reset (i_rst_n low, synchronous) empties both registers, ends any round and
// loads the configuration defaults: no targets, interval 15, max retries 5.
module notify_retry_sender #(
    parameter int MAX_TARGETS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  nrs_pkg::t_in_item              i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output nrs_pkg::t_out_item             o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  nrs_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [nrs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nrs_pkg::*;

    // Input register: holds one accepted transfer until the engine can take it.
    logic      r_in_valid;
    t_in_item  r_in_data;
    // Result register: the engine writes here; the output channel drains it.
    logic      r_out_valid;
    t_out_item r_out_data;

    t_cfg      cfg;
    t_out_item result;
    logic      go;
    logic      in_take;

    // The engine processes the held item when the result register is empty
    // or is being emptied in this same cycle.
    assign go      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;

    // The input register can refill in the cycle it hands its item over.
    assign o_in_stall = r_in_valid && !go;

    nrs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    nrs_engine #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end

            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (go) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !go |=> r_in_valid && $stable(r_in_data))
        else $error("held input item lost before processing");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result changed before its transfer");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled while the input register is empty");
`endif

endmodule

@@ rtl/core/nrs_cfg_regs.sv @@
`timescale 1ns / 1ps

module nrs_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  nrs_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [nrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output nrs_pkg::t_cfg                      o_cfg
);
    import nrs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_count   <= '0;
            r_cfg.retry_interval <= RETRY_INTERVAL_RST;
            r_cfg.max_retries    <= MAX_RETRIES_RST;
            r_cfg.soa_known      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_COUNT:   r_cfg.target_count   <= i_cfg_data[TCOUNT_W-1:0];
                CFG_RETRY_INTERVAL: r_cfg.retry_interval <= i_cfg_data[INTERVAL_W-1:0];
                CFG_MAX_RETRIES:    r_cfg.max_retries    <= i_cfg_data[MAXRET_W-1:0];
                CFG_SOA_KNOWN:      r_cfg.soa_known      <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/nrs_engine.sv @@
`timescale 1ns / 1ps

module nrs_engine #(
    parameter int MAX_TARGETS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  nrs_pkg::t_in_item  i_item,
    input  nrs_pkg::t_cfg      i_cfg,
    output nrs_pkg::t_out_item o_result
);
    import nrs_pkg::*;

    localparam int TW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CMPW = (TW + 1 > TCOUNT_W) ? TW + 1 : TCOUNT_W;

    logic                  r_active;
    logic [TW-1:0]         r_cur;
    logic [ATTEMPT_W-1:0]  r_retry;
    logic [INTERVAL_W-1:0] r_cd;
    logic [ID_W-1:0]       r_pid;

    logic                  n_active;
    logic [TW-1:0]         n_cur;
    logic [ATTEMPT_W-1:0]  n_retry;
    logic [INTERVAL_W-1:0] n_cd;
    logic [ID_W-1:0]       n_pid;

    logic [CMPW-1:0]       tc_ext;
    logic [CMPW-1:0]       eff_count;
    logic                  is_last;
    logic                  reply_good;
    logic                  timeout;
    logic [ATTEMPT_W-1:0]  retry_inc;
    logic                  adv;
    logic                  send;
    logic                  fin;

    // Target count is clamped to the list capacity.
    assign tc_ext    = CMPW'(i_cfg.target_count);
    assign eff_count = (tc_ext > CMPW'(MAX_TARGETS)) ? CMPW'(MAX_TARGETS) : tc_ext;
    assign is_last   = (CMPW'(r_cur) + CMPW'(1)) >= eff_count;

    assign reply_good = (i_item.reply_opcode == OPC_NOTIFY) && i_item.reply_is_response &&
                        (i_item.reply_id == r_pid) &&
                        ((i_item.reply_rcode == RCODE_NOERROR) ||
                         (i_item.reply_rcode == RCODE_NOTIMP));
    assign timeout    = r_cd <= INTERVAL_W'(1);
    assign retry_inc  = r_retry + ATTEMPT_W'(1);

    always_comb begin
        n_active = r_active;
        n_cur    = r_cur;
        n_retry  = r_retry;
        n_cd     = r_cd;
        n_pid    = r_pid;
        adv      = 1'b0;
        send     = 1'b0;
        fin      = 1'b0;

        unique case (i_item.kind)
            KIND_START: begin
                if (eff_count != '0) begin
                    n_active = 1'b1;
                    n_cur    = '0;
                    n_retry  = '0;
                    n_cd     = '0;
                end
            end
            KIND_REPLY: begin
                if (r_active) begin
                    adv  = reply_good;
                    send = 1'b1;
                end
            end
            KIND_TICK: begin
                if (r_active) begin
                    if (timeout) begin
                        n_retry = retry_inc;
                        adv     = retry_inc > ATTEMPT_W'(i_cfg.max_retries);
                        send    = 1'b1;
                    end else begin
                        n_cd = r_cd - INTERVAL_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        // Moving past the last target closes the round and suppresses the send.
        if (adv) begin
            n_retry = '0;
            if (is_last) begin
                n_active = 1'b0;
                n_cur    = '0;
                n_cd     = '0;
                fin      = 1'b1;
                send     = 1'b0;
            end else begin
                n_cur = r_cur + TW'(1);
            end
        end

        if (send) begin
            n_pid = i_item.fresh_id;
            n_cd  = i_cfg.retry_interval;
        end

        o_result.send_now       = send;
        o_result.target_index   = TIDX_W'(n_cur);
        o_result.sent_id        = send ? n_pid : '0;
        o_result.attempt_number = send ? n_retry : '0;
        o_result.include_soa    = send & i_cfg.soa_known;
        o_result.busy_res       = n_active;
        o_result.finished       = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cur    <= '0;
            r_retry  <= '0;
            r_cd     <= '0;
            r_pid    <= '0;
        end else if (i_go) begin
            r_active <= n_active;
            r_cur    <= n_cur;
            r_retry  <= n_retry;
            r_cd     <= n_cd;
            r_pid    <= n_pid;
        end
    end

`ifndef SYNTHESIS
    a_idle_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_cur == '0) && (r_retry == '0) && (r_cd == '0))
        else $error("idle engine holds stale round state");

    a_finish_ends_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && o_result.finished |=> !r_active)
        else $error("round still active after finishing");

    a_send_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && o_result.send_now |=>
            (r_cd == $past(i_cfg.retry_interval)) && (r_pid == $past(i_item.fresh_id)))
        else $error("send did not reload countdown and pending ID");
`endif

endmodule

@@ bench/notify_retry_sender_test.sv @@
`timescale 1ns / 1ps

module notify_retry_sender_test;

    import nrs_pkg::*;

    // The block takes up to sixteen targets; larger counts are clamped to this.
    localparam int TARGET_LIMIT = 16;
    // We let the settle pause pass after the last result before a register write.
    localparam int SETTLE_CYCLES = 4;
    localparam int FINAL_CYCLES = 8;
    localparam int ITEM_GOAL = 2000;
    localparam int MAX_GAP = 18;
    localparam int REPORT_LIMIT = 10;
    // Slowest correct run: about 2100 items, each one waiting out a full sender gap,
    // a full receiver stall and the latency. The timeout lies well above that.
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    // The kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // What the input driver does next: present an item, write a register, wait
    // until every expected result has come back, or sit idle for a few cycles.
    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN,
        STEP_SETTLE
    } t_step_op;

    // One entry of the stimulus queue. When echo is set, the reply ID of the item
    // is XORed with the ID of the notify in flight at the time it is presented,
    // so a zero mask gives a reply that matches.
    typedef struct {
        t_step_op                op;
        t_in_item                item;
        logic                    echo;
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
        int unsigned             gap;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_TARGET_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    notify_retry_sender #(
        .MAX_TARGETS(TARGET_LIMIT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Stimulus, expectations and bookkeeping shared by the processes below.
    t_step       steps_q[$];
    t_out_item   decisions_due[$];
    t_step       cur;
    logic        have_cur = 1'b0;
    int unsigned hold = 0;
    int unsigned stall_left = 0;
    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int          mismatches = 0;
    int          item_total = 0;

    // Our own copy of the configuration registers, at their reset values.
    logic [TCOUNT_W-1:0]   cfg_tcount = '0;
    logic [INTERVAL_W-1:0] cfg_interval = RETRY_INTERVAL_RST;
    logic [MAXRET_W-1:0]   cfg_maxret = MAX_RETRIES_RST;
    logic                  cfg_soa = 1'b0;

    // Our own copy of the round state.
    logic                  round_on = 1'b0;
    logic [TIDX_W-1:0]     cur_tgt = '0;
    logic [ATTEMPT_W-1:0]  retries = '0;
    logic [INTERVAL_W-1:0] cdown = '0;
    logic [ID_W-1:0]       pend_id = '0;

    // Clock with a 10 ns period.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Number of targets that the round really walks: anything above the list
    // size counts as a full list.
    function automatic int live_count();
        return (int'(cfg_tcount) > TARGET_LIMIT) ? TARGET_LIMIT : int'(cfg_tcount);
    endfunction

    // Move on to the next target. Passing the last one closes the round and
    // clears its state; the return value tells whether that happened.
    function automatic logic next_target();
        retries = '0;
        if (int'(cur_tgt) + 1 >= live_count()) begin
            round_on = 1'b0;
            cur_tgt = '0;
            cdown = '0;
            return 1'b1;
        end
        cur_tgt = cur_tgt + 1'b1;
        return 1'b0;
    endfunction

    // Apply one accepted input item to the round state and return the decision
    // that the block must report for it.
    function automatic t_out_item notify_step(input t_in_item it);
        t_out_item res;
        logic      sent;
        logic      done;
        logic      good;
        sent = 1'b0;
        done = 1'b0;
        case (it.kind)
            KIND_START: begin
                // With no targets a start does nothing; otherwise the round
                // (re)starts at target 0 with its timeout armed at once.
                if (live_count() != 0) begin
                    round_on = 1'b1;
                    cur_tgt = '0;
                    retries = '0;
                    cdown = '0;
                end
            end
            KIND_REPLY: begin
                if (round_on) begin
                    good = (it.reply_opcode == OPC_NOTIFY) && it.reply_is_response &&
                           (it.reply_id == pend_id) &&
                           (it.reply_rcode == RCODE_NOERROR || it.reply_rcode == RCODE_NOTIMP);
                    if (good) begin
                        done = next_target();
                    end
                    sent = round_on;
                end
            end
            KIND_TICK: begin
                if (round_on) begin
                    // A countdown of zero or one means the timeout is due now.
                    if (cdown <= 1) begin
                        retries = retries + 1'b1;
                        if (retries > cfg_maxret) begin
                            done = next_target();
                        end
                        sent = round_on;
                    end else begin
                        cdown = cdown - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (sent) begin
            pend_id = it.fresh_id;
            cdown = cfg_interval;
        end
        res.send_now = sent;
        res.target_index = cur_tgt;
        res.sent_id = sent ? pend_id : '0;
        res.attempt_number = sent ? retries : '0;
        res.include_soa = sent ? cfg_soa : 1'b0;
        res.busy_res = round_on;
        res.finished = done;
        return res;
    endfunction

    function automatic int unsigned draw_gap(input logic calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Queue one input item. The fresh ID is always random, so every send
    // carries a freshly drawn ID.
    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [OPCODE_W-1:0] opc,
                             input logic qr, input logic [ID_W-1:0] rid,
                             input logic [RCODE_W-1:0] rcode, input logic echo);
        t_step s;
        s.op = STEP_ITEM;
        s.item.kind = kind;
        s.item.reply_opcode = opc;
        s.item.reply_is_response = qr;
        s.item.reply_id = rid;
        s.item.reply_rcode = rcode;
        s.item.fresh_id = ID_W'($urandom);
        s.echo = echo;
        s.gap = draw_gap(tx_calm);
        steps_q.push_back(s);
        item_total++;
    endtask

    // Queue an item of the given kind with every other field random.
    task automatic push_noise(input logic [KIND_W-1:0] kind);
        push_item(kind, OPCODE_W'($urandom), 1'($urandom), ID_W'($urandom),
                  RCODE_W'($urandom), 1'b0);
    endtask

    // Queue a register write. The narrow registers sometimes get junk above
    // their width, which the block must drop.
    task automatic push_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        t_step                 s;
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        case (idx)
            CFG_TARGET_COUNT: junk[TCOUNT_W-1:0] = '0;
            CFG_MAX_RETRIES:  junk[MAXRET_W-1:0] = '0;
            CFG_SOA_KNOWN:    junk[0] = 1'b0;
            default:          junk = '0;
        endcase
        s.op = STEP_CFG;
        s.idx = idx;
        s.data = ($urandom_range(0, 3) == 0) ? (value | junk) : value;
        s.echo = 1'b0;
        s.gap = 0;
        steps_q.push_back(s);
    endtask

    // Queue a pause that lasts until every expected result has come back.
    task automatic push_drain();
        t_step s;
        s.op = STEP_DRAIN;
        s.echo = 1'b0;
        s.gap = 0;
        steps_q.push_back(s);
    endtask

    // Input driver. All inputs change at the falling edge. A transfer that was
    // taken at the last rising edge frees the channel for the next entry; a
    // valid that stays high for a back-to-back item gets one assignment only.
    always @(negedge i_clk) begin : feed
        logic                  nv;
        t_in_item              nd;
        logic                  nwe;
        t_cfg_idx              nidx;
        logic [CFG_DATA_W-1:0] ndata;
        nv = i_in_valid;
        nd = i_in_data;
        nwe = 1'b0;
        nidx = i_cfg_idx;
        ndata = i_cfg_data;
        if (i_rst_n) begin
            if (nv && in_fire) begin
                nv = 1'b0;
            end
            if (!nv) begin
                if (!have_cur && steps_q.size() != 0) begin
                    cur = steps_q.pop_front();
                    have_cur = 1'b1;
                    hold = cur.gap;
                end
                if (have_cur) begin
                    if (hold != 0) begin
                        hold--;
                    end else begin
                        case (cur.op)
                            STEP_ITEM: begin
                                nv = 1'b1;
                                nd = cur.item;
                                // The predictor has already seen every earlier
                                // item, so its pending ID is the one in flight.
                                if (cur.echo) begin
                                    nd.reply_id = pend_id ^ cur.item.reply_id;
                                end
                                have_cur = 1'b0;
                            end
                            STEP_CFG: begin
                                nwe = 1'b1;
                                nidx = cur.idx;
                                ndata = cur.data;
                                have_cur = 1'b0;
                            end
                            STEP_DRAIN: begin
                                if (decisions_due.size() == 0) begin
                                    cur.op = STEP_SETTLE;
                                    hold = SETTLE_CYCLES;
                                end
                            end
                            default: have_cur = 1'b0;
                        endcase
                    end
                end
            end
        end
        i_in_valid <= nv;
        i_in_data <= nd;
        i_cfg_we <= nwe;
        i_cfg_idx <= nidx;
        i_cfg_data <= ndata;
    end

    // Result receiver. For every result it draws a number of cycles to stall
    // while that result is offered; now and then it switches to stretches with
    // no stalls at all.
    always @(negedge i_clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 63) == 0) begin
                rx_calm = ~rx_calm;
            end
            stall_left = draw_gap(rx_calm);
        end else if (o_out_valid === 1'b1 && stall_left != 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left != 0);
    end

    // Monitor. At each rising edge it checks a result transfer against the
    // oldest expectation, mirrors register writes, and predicts the result of
    // an input transfer. The check comes first, since a result can never
    // belong to the item taken at the same edge.
    always @(posedge i_clk) begin : observe
        t_out_item want;
        logic      take_in;
        logic      take_out;
        take_in = (i_in_valid === 1'b1) && (o_in_stall === 1'b0);
        take_out = (o_out_valid === 1'b1) && (i_out_stall === 1'b0);
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire <= take_in;
            out_fire <= take_out;
            if (take_out) begin
                if (decisions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected: %p", $realtime, o_out_data);
                    end
                end else begin
                    want = decisions_due.pop_front();
                    if (o_out_data.send_now !== want.send_now ||
                        o_out_data.target_index !== want.target_index ||
                        o_out_data.sent_id !== want.sent_id ||
                        o_out_data.attempt_number !== want.attempt_number ||
                        o_out_data.include_soa !== want.include_soa ||
                        o_out_data.busy_res !== want.busy_res ||
                        o_out_data.finished !== want.finished) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch expected %p", $realtime, want);
                            $display("%0t:          actual   %p", $realtime, o_out_data);
                        end
                    end
                end
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_TARGET_COUNT:   cfg_tcount = i_cfg_data[TCOUNT_W-1:0];
                    CFG_RETRY_INTERVAL: cfg_interval = i_cfg_data[INTERVAL_W-1:0];
                    CFG_MAX_RETRIES:    cfg_maxret = i_cfg_data[MAXRET_W-1:0];
                    CFG_SOA_KNOWN:      cfg_soa = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (take_in) begin
                decisions_due.push_back(notify_step(i_in_data));
            end
        end
    end

    // Fill the stimulus queue, hold reset, then wait for the run to drain.
    initial begin : run
        int                   r;
        int                   len;
        logic [ID_W-1:0]      mask;
        logic [OPCODE_W-1:0]  opc;
        logic [RCODE_W-1:0]   rc;

        // Directed part. With no targets configured, every kind of item is
        // ignored, including the kind that has no meaning.
        push_item(KIND_START, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b0);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b0);
        push_item(KIND_TICK, 4'hF, 1'b1, 16'hFFFF, 4'hF, 1'b0);
        push_item(KIND_UNUSED, 4'hF, 1'b1, 16'hFFFF, 4'hF, 1'b0);

        // Two targets, zero interval, no retries: the first tick times out at
        // once and abandons target 0, the next one abandons the last target.
        push_drain();
        push_cfg(CFG_TARGET_COUNT, 16'd2);
        push_cfg(CFG_RETRY_INTERVAL, 16'd0);
        push_cfg(CFG_MAX_RETRIES, 16'd0);
        push_cfg(CFG_SOA_KNOWN, 16'd1);
        push_item(KIND_START, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_TICK, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_TICK, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);

        // Good reply, then each way a reply can be rejected, then a NOTIMP
        // reply that completes the last target. A start in the middle of a
        // round begins it again at target 0.
        push_item(KIND_START, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b1);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, 4'd2, 1'b1);
        push_item(KIND_REPLY, 4'hF, 1'b1, 16'h0000, RCODE_NOERROR, 1'b1);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b0, 16'h0000, RCODE_NOERROR, 1'b1);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'hFFFF, RCODE_NOERROR, 1'b1);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOTIMP, 1'b1);
        push_item(KIND_START, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b1);
        push_item(KIND_START, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);

        // Target count above the list size, longest interval, most retries.
        push_drain();
        push_cfg(CFG_TARGET_COUNT, 16'd31);
        push_cfg(CFG_RETRY_INTERVAL, 16'hFFFF);
        push_cfg(CFG_MAX_RETRIES, 16'd15);
        push_cfg(CFG_SOA_KNOWN, 16'd0);
        push_item(KIND_START, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_TICK, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_TICK, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b1);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b1);

        // Lower the target count under the current target while the round is
        // on: the next advance must end the round.
        push_drain();
        push_cfg(CFG_TARGET_COUNT, 16'd1);
        push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, RCODE_NOERROR, 1'b1);

        // Random part: phases of one configuration each. Every phase starts
        // once the block has gone quiet, so the sender pauses until all
        // expected results are back before each set of register writes.
        while (item_total < ITEM_GOAL) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            push_drain();
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_cfg(CFG_TARGET_COUNT, 16'd0);
            end else if (r < 20) begin
                push_cfg(CFG_TARGET_COUNT, 16'd16);
            end else if (r < 28) begin
                push_cfg(CFG_TARGET_COUNT, 16'($urandom_range(17, 31)));
            end else if (r < 40) begin
                push_cfg(CFG_TARGET_COUNT, 16'd1);
            end else begin
                push_cfg(CFG_TARGET_COUNT, 16'($urandom_range(2, 6)));
            end
            if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    push_cfg(CFG_RETRY_INTERVAL, 16'd0);
                end else if (r < 25) begin
                    push_cfg(CFG_RETRY_INTERVAL, 16'hFFFF);
                end else if (r < 35) begin
                    push_cfg(CFG_RETRY_INTERVAL, 16'($urandom));
                end else begin
                    push_cfg(CFG_RETRY_INTERVAL, 16'($urandom_range(1, 4)));
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    push_cfg(CFG_MAX_RETRIES, 16'd0);
                end else if (r < 40) begin
                    push_cfg(CFG_MAX_RETRIES, 16'd15);
                end else begin
                    push_cfg(CFG_MAX_RETRIES, 16'($urandom_range(0, 5)));
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                push_cfg(CFG_SOA_KNOWN, 16'($urandom_range(0, 1)));
            end

            // Mostly well-formed rounds: a start, then good replies and ticks,
            // with broken replies, restarts and plain noise mixed in.
            push_noise(KIND_START);
            len = $urandom_range(20, 90);
            repeat (len) begin
                r = $urandom_range(0, 99);
                rc = ($urandom_range(0, 1) == 0) ? RCODE_NOERROR : RCODE_NOTIMP;
                if (r < 40) begin
                    push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, rc, 1'b1);
                end else if (r < 70) begin
                    push_noise(KIND_TICK);
                end else if (r < 82) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            opc = OPCODE_W'($urandom);
                            if (opc == OPC_NOTIFY) opc = ~opc;
                            push_item(KIND_REPLY, opc, 1'b1, 16'h0000, rc, 1'b1);
                        end
                        1: push_item(KIND_REPLY, OPC_NOTIFY, 1'b0, 16'h0000, rc, 1'b1);
                        2: begin
                            mask = ID_W'($urandom_range(1, 16'hFFFF));
                            push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, mask, rc, 1'b1);
                        end
                        default: begin
                            rc = RCODE_W'($urandom);
                            if (rc == RCODE_NOERROR || rc == RCODE_NOTIMP) rc = rc + 4'd1;
                            push_item(KIND_REPLY, OPC_NOTIFY, 1'b1, 16'h0000, rc, 1'b1);
                        end
                    endcase
                end else if (r < 87) begin
                    push_noise(KIND_START);
                end else if (r < 95) begin
                    push_noise(KIND_W'($urandom));
                end else begin
                    push_noise(KIND_UNUSED);
                end
            end
        end

        // Synchronous reset, released at a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (steps_q.size() != 0 || have_cur || i_in_valid || decisions_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FINAL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && decisions_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard limit on the run in case a handshake hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
